// ----- rtl/pee_pkg.sv -----
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and constants for the postfix expression evaluator: character
// codes, status codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package pee_pkg;

   localparam logic [7:0] SYM_ZERO  = 8'h30;
   localparam logic [7:0] SYM_NINE  = 8'h39;
   localparam logic [7:0] SYM_PLUS  = 8'h2B;
   localparam logic [7:0] SYM_MINUS = 8'h2D;
   localparam logic [7:0] SYM_STAR  = 8'h2A;
   localparam logic [7:0] SYM_SLASH = 8'h2F;

   localparam int DIV_STEPS = 32;
   localparam int DIV_CW    = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_UNDERFLOW = 3'd1,
      STATUS_OVERFLOW  = 3'd2,
      STATUS_DIVZERO   = 3'd3,
      STATUS_INVALID   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      KIND_DIGIT,
      KIND_ADD,
      KIND_SUB,
      KIND_MUL,
      KIND_DIV,
      KIND_INVALID
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_EXEC,
      ST_DIV,
      ST_DIVEND,
      ST_WRITE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       push;
      logic       exec;
      logic       div_start;
      logic       div_step;
      logic       div_done;
      logic       pop_write;
      logic       set_err;
      status_type err_code;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     full;
      logic     lt2;
      logic     rhs_zero;
      logic     div_last;
      logic     out_busy;
      logic     last;
   } stat_type;

   function automatic kind_type decode_symbol(input logic [7:0] sym);
      kind_type k;
      k = KIND_INVALID;
      if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
         k = KIND_DIGIT;
      end else if (sym == SYM_PLUS) begin
         k = KIND_ADD;
      end else if (sym == SYM_MINUS) begin
         k = KIND_SUB;
      end else if (sym == SYM_STAR) begin
         k = KIND_MUL;
      end else if (sym == SYM_SLASH) begin
         k = KIND_DIV;
      end
      return k;
   endfunction

endpackage

// ----- rtl/pee_controller.sv -----
// ----------------------------------------------------------------------------
// pee_controller
// Sequencer for one item at a time: accept, decode, operate, write back and,
// on the last item of an expression, load the result register.
// ----------------------------------------------------------------------------
module pee_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pee_pkg::stat_type  stat,
   output pee_pkg::cmd_type   cmd
);

   pee_pkg::state_type state_ff;
   pee_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pee_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         pee_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = pee_pkg::ST_DECODE;
            end
         end
         pee_pkg::ST_DECODE: begin
            state_in = pee_pkg::ST_FINISH;
            case (stat.kind)
               pee_pkg::KIND_DIGIT: begin
                  if (stat.full) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = pee_pkg::STATUS_OVERFLOW;
                  end else begin
                     cmd.push = 1'b1;
                  end
               end
               pee_pkg::KIND_ADD, pee_pkg::KIND_SUB, pee_pkg::KIND_MUL: begin
                  if (stat.lt2) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = pee_pkg::STATUS_UNDERFLOW;
                  end else begin
                     state_in = pee_pkg::ST_EXEC;
                  end
               end
               pee_pkg::KIND_DIV: begin
                  if (stat.lt2) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = pee_pkg::STATUS_UNDERFLOW;
                  end else if (stat.rhs_zero) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = pee_pkg::STATUS_DIVZERO;
                  end else begin
                     state_in = pee_pkg::ST_EXEC;
                  end
               end
               default: begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = pee_pkg::STATUS_INVALID;
               end
            endcase
         end
         pee_pkg::ST_EXEC: begin
            if (stat.kind == pee_pkg::KIND_DIV) begin
               cmd.div_start = 1'b1;
               state_in      = pee_pkg::ST_DIV;
            end else begin
               cmd.exec = 1'b1;
               state_in = pee_pkg::ST_WRITE;
            end
         end
         pee_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = pee_pkg::ST_DIVEND;
            end
         end
         pee_pkg::ST_DIVEND: begin
            cmd.div_done = 1'b1;
            state_in     = pee_pkg::ST_WRITE;
         end
         pee_pkg::ST_WRITE: begin
            cmd.pop_write = 1'b1;
            state_in      = pee_pkg::ST_FINISH;
         end
         pee_pkg::ST_FINISH: begin
            if (!stat.last) begin
               state_in = pee_pkg::ST_IDLE;
            end else if (!stat.out_busy) begin
               cmd.emit = 1'b1;
               state_in = pee_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pee_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/pee_datapath.sv -----
// ----------------------------------------------------------------------------
// pee_datapath
// Operand stack (top entry in a register, the rest in a memory), adder,
// multiplier, iterative divider, sticky error and the result register.
// ----------------------------------------------------------------------------
module pee_datapath #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               req_symbol,
   input  logic                     req_last,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [31:0]       rsp_value,
   output logic [2:0]               rsp_status,
   input  pee_pkg::cmd_type         cmd,
   output pee_pkg::stat_type        stat
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [31:0] mem [STACK_DEPTH];

   logic [7:0]              sym_ff;
   logic                    last_ff;
   logic [CW-1:0]           count_ff, count_in;
   logic [31:0]             tos_ff, tos_in;
   logic [31:0]             rd_ff;
   logic [31:0]             res_ff, res_in;
   pee_pkg::status_type     err_ff, err_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [31:0]             rsp_value_ff;
   pee_pkg::status_type     rsp_status_ff;

   logic [31:0]             dv_rem_ff, dv_rem_in;
   logic [31:0]             dv_quo_ff, dv_quo_in;
   logic [31:0]             dv_den_ff, dv_den_in;
   logic                    dv_neg_ff, dv_neg_in;
   logic [pee_pkg::DIV_CW-1:0] dv_cnt_ff, dv_cnt_in;

   logic [CW-1:0]           cnt_m1, cnt_m2;
   logic [AW-1:0]           wr_addr, rd_addr;
   logic [7:0]              digit_val;
   logic [32:0]             dv_shift, dv_diff;
   logic [31:0]             mag_a, mag_b;
   pee_pkg::status_type     out_status;

   assign cnt_m1    = count_ff - CW'(1);
   assign cnt_m2    = count_ff - CW'(2);
   assign wr_addr   = cnt_m1[AW-1:0];
   assign rd_addr   = cnt_m2[AW-1:0];
   assign digit_val = sym_ff - pee_pkg::SYM_ZERO;
   assign mag_a     = rd_ff[31] ? (32'd0 - rd_ff) : rd_ff;
   assign mag_b     = tos_ff[31] ? (32'd0 - tos_ff) : tos_ff;
   assign dv_shift  = {dv_rem_ff, dv_quo_ff[31]};
   assign dv_diff   = dv_shift - {1'b0, dv_den_ff};

   // stack memory, below-top entries only
   always_ff @(posedge clock) begin
      if (cmd.push && count_ff != '0) begin
         mem[wr_addr] <= tos_ff;
      end
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      if (err_ff != pee_pkg::STATUS_OK) begin
         out_status = err_ff;
      end else if (count_ff == '0) begin
         out_status = pee_pkg::STATUS_UNDERFLOW;
      end else begin
         out_status = pee_pkg::STATUS_OK;
      end
   end

   always_comb begin
      count_in = count_ff;
      tos_in   = tos_ff;
      res_in   = res_ff;
      err_in   = err_ff;
      if (cmd.push) begin
         count_in = count_ff + CW'(1);
         tos_in   = {24'd0, digit_val};
      end
      if (cmd.pop_write) begin
         count_in = cnt_m1;
         tos_in   = res_ff;
      end
      if (cmd.exec) begin
         case (stat.kind)
            pee_pkg::KIND_ADD: res_in = rd_ff + tos_ff;
            pee_pkg::KIND_SUB: res_in = rd_ff - tos_ff;
            pee_pkg::KIND_MUL: res_in = rd_ff * tos_ff;
            default:           res_in = res_ff;
         endcase
      end
      if (cmd.div_done) begin
         res_in = dv_neg_ff ? (32'd0 - dv_quo_ff) : dv_quo_ff;
      end
      if (cmd.set_err && err_ff == pee_pkg::STATUS_OK) begin
         err_in = cmd.err_code;
      end
      if (cmd.emit) begin
         count_in = '0;
         err_in   = pee_pkg::STATUS_OK;
      end
   end

   always_comb begin
      dv_rem_in = dv_rem_ff;
      dv_quo_in = dv_quo_ff;
      dv_den_in = dv_den_ff;
      dv_neg_in = dv_neg_ff;
      dv_cnt_in = dv_cnt_ff;
      if (cmd.div_start) begin
         dv_rem_in = '0;
         dv_quo_in = mag_a;
         dv_den_in = mag_b;
         dv_neg_in = rd_ff[31] ^ tos_ff[31];
         dv_cnt_in = '0;
      end else if (cmd.div_step) begin
         if (!dv_diff[32]) begin
            dv_rem_in = dv_diff[31:0];
            dv_quo_in = {dv_quo_ff[30:0], 1'b1};
         end else begin
            dv_rem_in = dv_shift[31:0];
            dv_quo_in = {dv_quo_ff[30:0], 1'b0};
         end
         dv_cnt_in = dv_cnt_ff + pee_pkg::DIV_CW'(1);
      end
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         err_ff       <= pee_pkg::STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sym_ff  <= req_symbol;
         last_ff <= req_last;
      end
      if (cmd.emit) begin
         rsp_status_ff <= out_status;
         rsp_value_ff  <= (out_status == pee_pkg::STATUS_OK) ? tos_ff : 32'd0;
      end
      tos_ff    <= tos_in;
      res_ff    <= res_in;
      dv_rem_ff <= dv_rem_in;
      dv_quo_ff <= dv_quo_in;
      dv_den_ff <= dv_den_in;
      dv_neg_ff <= dv_neg_in;
      dv_cnt_ff <= dv_cnt_in;
   end

   assign stat.kind     = pee_pkg::decode_symbol(sym_ff);
   assign stat.full     = count_ff >= CW'(STACK_DEPTH);
   assign stat.lt2      = count_ff < CW'(2);
   assign stat.rhs_zero = tos_ff == 32'd0;
   assign stat.div_last = dv_cnt_ff == pee_pkg::DIV_CW'(pee_pkg::DIV_STEPS - 1);
   assign stat.out_busy = rsp_valid_ff && rsp_stall;
   assign stat.last     = last_ff;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ----- rtl/postfix_expression_evaluator.sv -----
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates a postfix expression arriving one character per item. Digits are
// pushed, + - * / combine the two top entries, and the item marked last
// produces one result (value and status) and clears the stack and error.
// One item is worked on at a time. A digit, an invalid character or an
// operator that raises an error goes from decode straight to the finish
// state; other + - * pass through the operate and write-back states, and /
// also runs the 32-step shift-subtract divider. A last item whose result
// finds the result register still stalled waits there until it is taken.
// The stack keeps its top entry in a register and the rest in a memory.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
   parameter int STACK_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_symbol,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic [2:0]         rsp_status
);

   pee_pkg::cmd_type  cmd;
   pee_pkg::stat_type stat;

   pee_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pee_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_symbol (req_symbol),
      .req_last   (req_last),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

// ----- rtl/pee_checker.sv -----
// ----------------------------------------------------------------------------
// pee_checker
// Port-level checks for the postfix expression evaluator, bound to the top.
// ----------------------------------------------------------------------------
module pee_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_value,
   input logic [2:0]  rsp_status
);

   logic req_accept;
   assign req_accept = req_valid && !req_stall;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("item taken while previous item in progress");

   a_error_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != pee_pkg::STATUS_OK |-> rsp_value == 32'd0)
      else $error("nonzero value with error status");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= pee_pkg::STATUS_INVALID)
      else $error("status code out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("stalled item changed");

endmodule

bind postfix_expression_evaluator pee_checker u_checker (.*);
